/* design/clwt_pkg.sv */
// ----------------------------------------------------------------------------
// clwt_pkg
// shared constants, types and helpers of the coset leader weight table
// ----------------------------------------------------------------------------
package clwt_pkg;

   localparam int MAX_SYNDROME_BITS = 16;
   localparam int MAX_GENERATORS    = 16;
   localparam int DISTANCE_CAP      = 63;
   localparam int NUM_BINS          = 64;

   localparam int TBL_AW  = MAX_SYNDROME_BITS;
   localparam int TBL_DW  = 6;
   localparam int HIST_AW = 6;
   localparam int HIST_DW = 17;
   localparam int GEN_AW  = $clog2(MAX_GENERATORS);
   localparam int GEN_CW  = $clog2(MAX_GENERATORS + 1);

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_RUN    = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [2:0] REG_SYNDROME_WIDTH = 3'd0;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [TBL_AW-1:0] addr;
      logic [TBL_DW-1:0] wdata;
   } tbl_port_type;

   typedef struct packed {
      logic               en;
      logic               we;
      logic [HIST_AW-1:0] addr;
      logic [HIST_DW-1:0] wdata;
   } hist_port_type;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_FILL  = 14'b00000000000010,
      ST_GSTEP = 14'b00000000000100,
      ST_GWR   = 14'b00000000001000,
      ST_BRD   = 14'b00000000010000,
      ST_BWR   = 14'b00000000100000,
      ST_HCLR  = 14'b00000001000000,
      ST_HRD   = 14'b00000010000000,
      ST_HRH   = 14'b00000100000000,
      ST_HWR   = 14'b00001000000000,
      ST_ERD   = 14'b00010000000000,
      ST_EOUT  = 14'b00100000000000,
      ST_LRD   = 14'b01000000000000,
      ST_LOUT  = 14'b10000000000000
   } state_type;

   // index of the lowest set bit
   function automatic logic [GEN_AW-1:0] low_zeros(input logic [GEN_AW*0+MAX_GENERATORS-1:0] v);
      logic [GEN_AW-1:0] n;
      n = '0;
      for (int i = MAX_GENERATORS - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = GEN_AW'(i);
         end
      end
      return n;
   endfunction

endpackage

/* design/clwt_table_ram.sv */
// ----------------------------------------------------------------------------
// clwt_table_ram
// dual port distance table, registered read on each port
// ----------------------------------------------------------------------------
module clwt_table_ram (
   input  logic                          clock,
   input  clwt_pkg::tbl_port_type        port_a,
   input  clwt_pkg::tbl_port_type        port_b,
   output logic [clwt_pkg::TBL_DW-1:0]   rdata_a,
   output logic [clwt_pkg::TBL_DW-1:0]   rdata_b
);

   logic [clwt_pkg::TBL_DW-1:0] mem [2**clwt_pkg::TBL_AW];

   always_ff @(posedge clock) begin
      if (port_a.en) begin
         if (port_a.we) begin
            mem[port_a.addr] <= port_a.wdata;
         end
         rdata_a <= mem[port_a.addr];
      end
      if (port_b.en) begin
         if (port_b.we) begin
            mem[port_b.addr] <= port_b.wdata;
         end
         rdata_b <= mem[port_b.addr];
      end
   end

endmodule

/* design/clwt_hist_ram.sv */
// ----------------------------------------------------------------------------
// clwt_hist_ram
// single port histogram store, registered read
// ----------------------------------------------------------------------------
module clwt_hist_ram (
   input  logic                          clock,
   input  clwt_pkg::hist_port_type       port,
   output logic [clwt_pkg::HIST_DW-1:0]  rdata
);

   logic [clwt_pkg::HIST_DW-1:0] mem [2**clwt_pkg::HIST_AW];

   always_ff @(posedge clock) begin
      if (port.en) begin
         if (port.we) begin
            mem[port.addr] <= port.wdata;
         end
         rdata <= mem[port.addr];
      end
   end

endmodule

/* design/coset_leader_weight_table.sv */
// ----------------------------------------------------------------------------
// coset_leader_weight_table
// min-plus hamming distance transform over a generator set, with histogram
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | tuser func, tdata mask and syndrome
//  rsp_     | out       | tuser status, tdata results, tlast end of item
//  csr_     | in/out    | apb port, syndrome_width at byte address 0
//
//  load and out-of-range lookup: answered in the cycle after the accept cycle
//  lookup: one read of the table ram in ST_LRD, answered from ST_LOUT
//  run: fill the table, walk the generator subsets in gray-code order, then
//       butterfly passes over each syndrome bit, a read and a write per pair,
//       then clear, build and emit the histogram, one result word per bin
//  one item at a time; a stalled result word holds the sequencer
//  reset is synchronous; table contents are undefined until a run
// ----------------------------------------------------------------------------
module coset_leader_weight_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // mask, syndrome
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [55:0] rsp_tdata,   // distance, bin, bin_count, peak distance,
                                    // first_max_syndrome, zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = clwt_pkg::TBL_AW;
   localparam int DW = clwt_pkg::TBL_DW;
   localparam int HW = clwt_pkg::HIST_DW;

   clwt_pkg::state_type state_ff, state_in;

   logic [4:0]      width_ff, width_in;
   logic [AW-1:0]   gen_ff [clwt_pkg::MAX_GENERATORS];
   logic [clwt_pkg::GEN_CW-1:0] gen_cnt_ff, gen_cnt_in;
   logic            gen_we;

   logic [AW:0]     x_ff, x_in;
   logic [AW:0]     step_ff, step_in;
   logic [AW-1:0]   center_ff, center_in;
   logic [AW-1:0]   gray_ff, gray_in;
   logic [4:0]      wt_ff, wt_in;
   logic [3:0]      bit_ff, bit_in;
   logic [DW-1:0]   val_ff, val_in;
   logic [5:0]      k_ff, k_in;
   logic [DW-1:0]   maxd_ff, maxd_in;
   logic [AW-1:0]   maxs_ff, maxs_in;
   logic [AW-1:0]   syn_ff, syn_in;

   logic            o_v_ff, o_v_in;
   logic [1:0]      o_st_ff, o_st_in;
   logic [DW-1:0]   o_dist_ff, o_dist_in;
   logic [5:0]      o_bin_ff, o_bin_in;
   logic [HW-1:0]   o_cnt_ff, o_cnt_in;
   logic [DW-1:0]   o_maxd_ff, o_maxd_in;
   logic [AW-1:0]   o_maxs_ff, o_maxs_in;
   logic            o_last_ff, o_last_in;

   clwt_pkg::tbl_port_type  pa, pb;
   clwt_pkg::hist_port_type ph;
   logic [DW-1:0]   ra, rb;
   logic [HW-1:0]   rh;

   logic [4:0]      w_eff;
   logic [AW:0]     size;
   logic [AW-1:0]   lim;
   logic [1:0]      func;
   logic [AW-1:0]   mask, syndrome;
   logic            req_fire, out_free, csr_write;
   logic [clwt_pkg::GEN_AW-1:0] idx;
   logic [AW-1:0]   half;
   logic [AW:0]     x_next;
   logic [DW:0]     a_p1, c_p1;

   clwt_table_ram u_table (
      .clock   (clock),
      .port_a  (pa),
      .port_b  (pb),
      .rdata_a (ra),
      .rdata_b (rb)
   );

   clwt_hist_ram u_hist (
      .clock (clock),
      .port  (ph),
      .rdata (rh)
   );

   assign func     = req_tuser;
   assign mask     = req_tdata[15:0];
   assign syndrome = req_tdata[31:16];
   assign out_free = !o_v_ff || rsp_tready;
   assign req_tready = (state_ff == clwt_pkg::ST_IDLE) && out_free;
   assign req_fire = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == clwt_pkg::REG_SYNDROME_WIDTH[0]);
   assign csr_prdata = (csr_paddr[2] == clwt_pkg::REG_SYNDROME_WIDTH[0]) ?
                       {27'd0, width_ff} : 32'd0;

   assign w_eff = (width_ff == 5'd0) ? 5'd1 :
                  (width_ff > 5'(clwt_pkg::MAX_SYNDROME_BITS)) ?
                  5'(clwt_pkg::MAX_SYNDROME_BITS) : width_ff;
   assign size  = (AW+1)'(1) << w_eff;
   assign lim   = AW'(size - (AW+1)'(1));

   assign idx    = clwt_pkg::low_zeros(step_ff[AW-1:0]);
   assign half   = AW'(1) << bit_ff;
   assign x_next = ({1'b0, x_ff[AW-1:0] | half} + (AW+1)'(1)) & ~{1'b0, half};
   assign a_p1   = {1'b0, ra} + (DW+1)'(1);
   assign c_p1   = {1'b0, rb} + (DW+1)'(1);

   assign rsp_tvalid = o_v_ff;
   assign rsp_tuser  = o_st_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {5'd0, o_maxs_ff, o_maxd_ff, o_cnt_ff, o_bin_ff, o_dist_ff};

   always_comb begin
      state_in   = state_ff;
      width_in   = csr_write ? csr_pwdata[4:0] : width_ff;
      gen_cnt_in = gen_cnt_ff;
      gen_we     = 1'b0;
      x_in       = x_ff;
      step_in    = step_ff;
      center_in  = center_ff;
      gray_in    = gray_ff;
      wt_in      = wt_ff;
      bit_in     = bit_ff;
      val_in     = val_ff;
      k_in       = k_ff;
      maxd_in    = maxd_ff;
      maxs_in    = maxs_ff;
      syn_in     = syn_ff;
      o_v_in     = o_v_ff && !rsp_tready;
      o_st_in    = o_st_ff;
      o_dist_in  = o_dist_ff;
      o_bin_in   = o_bin_ff;
      o_cnt_in   = o_cnt_ff;
      o_maxd_in  = o_maxd_ff;
      o_maxs_in  = o_maxs_ff;
      o_last_in  = o_last_ff;
      pa = '0;
      pb = '0;
      ph = '0;

      case (state_ff)
         clwt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  clwt_pkg::FUNC_LOAD: begin
                     o_v_in    = 1'b1;
                     o_dist_in = '0;
                     o_bin_in  = '0;
                     o_cnt_in  = '0;
                     o_maxd_in = '0;
                     o_maxs_in = '0;
                     o_last_in = 1'b1;
                     if (gen_cnt_ff >= clwt_pkg::GEN_CW'(clwt_pkg::MAX_GENERATORS)) begin
                        o_st_in = clwt_pkg::STATUS_FULL;
                     end else if ({1'b0, mask} >= size) begin
                        o_st_in = clwt_pkg::STATUS_RANGE;
                     end else begin
                        o_st_in    = clwt_pkg::STATUS_OK;
                        gen_we     = 1'b1;
                        gen_cnt_in = gen_cnt_ff + clwt_pkg::GEN_CW'(1);
                     end
                  end
                  clwt_pkg::FUNC_RUN: begin
                     x_in     = '0;
                     state_in = clwt_pkg::ST_FILL;
                  end
                  clwt_pkg::FUNC_LOOKUP: begin
                     if ({1'b0, syndrome} >= size) begin
                        o_v_in    = 1'b1;
                        o_st_in   = clwt_pkg::STATUS_RANGE;
                        o_dist_in = '0;
                        o_bin_in  = '0;
                        o_cnt_in  = '0;
                        o_maxd_in = '0;
                        o_maxs_in = '0;
                        o_last_in = 1'b1;
                     end else begin
                        syn_in   = syndrome;
                        state_in = clwt_pkg::ST_LRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         clwt_pkg::ST_FILL: begin
            pa.en    = 1'b1;
            pa.we    = 1'b1;
            pa.addr  = x_ff[AW-1:0];
            pa.wdata = (x_ff == '0) ? '0 : DW'(clwt_pkg::DISTANCE_CAP);
            if (x_ff[AW-1:0] == lim) begin
               step_in   = (AW+1)'(1);
               center_in = '0;
               gray_in   = '0;
               wt_in     = '0;
               x_in      = '0;
               bit_in    = '0;
               state_in  = (gen_cnt_ff == '0) ? clwt_pkg::ST_BRD : clwt_pkg::ST_GSTEP;
            end else begin
               x_in = x_ff + (AW+1)'(1);
            end
         end
         clwt_pkg::ST_GSTEP: begin
            center_in = (center_ff ^ gen_ff[idx]) & lim;
            wt_in     = gray_ff[idx] ? wt_ff - 5'd1 : wt_ff + 5'd1;
            gray_in   = gray_ff ^ (AW'(1) << idx);
            pa.en     = 1'b1;
            pa.addr   = (center_ff ^ gen_ff[idx]) & lim;
            state_in  = clwt_pkg::ST_GWR;
         end
         clwt_pkg::ST_GWR: begin
            if ({1'b0, wt_ff} < ra) begin
               pa.en    = 1'b1;
               pa.we    = 1'b1;
               pa.addr  = center_ff;
               pa.wdata = DW'(wt_ff);
            end
            if (step_ff + (AW+1)'(1) == ((AW+1)'(1) << gen_cnt_ff)) begin
               x_in     = '0;
               bit_in   = '0;
               state_in = clwt_pkg::ST_BRD;
            end else begin
               step_in  = step_ff + (AW+1)'(1);
               state_in = clwt_pkg::ST_GSTEP;
            end
         end
         clwt_pkg::ST_BRD: begin
            pa.en    = 1'b1;
            pa.addr  = x_ff[AW-1:0];
            pb.en    = 1'b1;
            pb.addr  = x_ff[AW-1:0] | half;
            state_in = clwt_pkg::ST_BWR;
         end
         clwt_pkg::ST_BWR: begin
            pa.en    = 1'b1;
            pa.we    = 1'b1;
            pa.addr  = x_ff[AW-1:0];
            pa.wdata = ({1'b0, ra} < c_p1) ? ra : DW'(c_p1);
            pb.en    = 1'b1;
            pb.we    = 1'b1;
            pb.addr  = x_ff[AW-1:0] | half;
            pb.wdata = ({1'b0, rb} < a_p1) ? rb : DW'(a_p1);
            if (x_next >= size) begin
               x_in = '0;
               if ({1'b0, bit_ff} == w_eff - 5'd1) begin
                  k_in     = '0;
                  maxd_in  = '0;
                  maxs_in  = '0;
                  state_in = clwt_pkg::ST_HCLR;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  state_in = clwt_pkg::ST_BRD;
               end
            end else begin
               x_in     = x_next;
               state_in = clwt_pkg::ST_BRD;
            end
         end
         clwt_pkg::ST_HCLR: begin
            ph.en    = 1'b1;
            ph.we    = 1'b1;
            ph.addr  = k_ff;
            ph.wdata = '0;
            if (k_ff == 6'(clwt_pkg::NUM_BINS - 1)) begin
               x_in     = '0;
               state_in = clwt_pkg::ST_HRD;
            end else begin
               k_in = k_ff + 6'd1;
            end
         end
         clwt_pkg::ST_HRD: begin
            pa.en    = 1'b1;
            pa.addr  = x_ff[AW-1:0];
            state_in = clwt_pkg::ST_HRH;
         end
         clwt_pkg::ST_HRH: begin
            ph.en   = 1'b1;
            ph.addr = ra;
            val_in  = ra;
            if (ra > maxd_ff) begin
               maxd_in = ra;
               maxs_in = x_ff[AW-1:0];
            end
            state_in = clwt_pkg::ST_HWR;
         end
         clwt_pkg::ST_HWR: begin
            ph.en    = 1'b1;
            ph.we    = 1'b1;
            ph.addr  = val_ff;
            ph.wdata = rh + HW'(1);
            if (x_ff[AW-1:0] == lim) begin
               k_in     = '0;
               state_in = clwt_pkg::ST_ERD;
            end else begin
               x_in     = x_ff + (AW+1)'(1);
               state_in = clwt_pkg::ST_HRD;
            end
         end
         clwt_pkg::ST_ERD: begin
            ph.en    = 1'b1;
            ph.addr  = k_ff;
            state_in = clwt_pkg::ST_EOUT;
         end
         clwt_pkg::ST_EOUT: begin
            if (out_free) begin
               o_v_in    = 1'b1;
               o_st_in   = clwt_pkg::STATUS_OK;
               o_dist_in = '0;
               o_bin_in  = k_ff;
               o_cnt_in  = rh;
               o_maxd_in = maxd_ff;
               o_maxs_in = maxs_ff;
               o_last_in = (k_ff == 6'(clwt_pkg::NUM_BINS - 1));
               if (k_ff == 6'(clwt_pkg::NUM_BINS - 1)) begin
                  state_in = clwt_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 6'd1;
                  state_in = clwt_pkg::ST_ERD;
               end
            end
         end
         clwt_pkg::ST_LRD: begin
            pa.en    = 1'b1;
            pa.addr  = syn_ff;
            state_in = clwt_pkg::ST_LOUT;
         end
         clwt_pkg::ST_LOUT: begin
            if (out_free) begin
               o_v_in    = 1'b1;
               o_st_in   = clwt_pkg::STATUS_OK;
               o_dist_in = ra;
               o_bin_in  = '0;
               o_cnt_in  = '0;
               o_maxd_in = '0;
               o_maxs_in = '0;
               o_last_in = 1'b1;
               state_in  = clwt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clwt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= clwt_pkg::ST_IDLE;
         width_ff   <= 5'(clwt_pkg::MAX_SYNDROME_BITS);
         gen_cnt_ff <= '0;
         o_v_ff     <= 1'b0;
         maxd_ff    <= '0;
         maxs_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         gen_cnt_ff <= gen_cnt_in;
         o_v_ff     <= o_v_in;
         maxd_ff    <= maxd_in;
         maxs_ff    <= maxs_in;
      end
      if (gen_we) begin
         gen_ff[gen_cnt_ff[clwt_pkg::GEN_AW-1:0]] <= mask;
      end
      x_ff      <= x_in;
      step_ff   <= step_in;
      center_ff <= center_in;
      gray_ff   <= gray_in;
      wt_ff     <= wt_in;
      bit_ff    <= bit_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      syn_ff    <= syn_in;
      o_st_ff   <= o_st_in;
      o_dist_ff <= o_dist_in;
      o_bin_ff  <= o_bin_in;
      o_cnt_ff  <= o_cnt_in;
      o_maxd_ff <= o_maxd_in;
      o_maxs_ff <= o_maxs_in;
      o_last_ff <= o_last_in;
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == clwt_pkg::ST_IDLE)
      else $error("item accepted while sequencer busy");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (pa.en && pa.we && pb.en && pb.we) |-> pa.addr != pb.addr)
      else $error("both table ports write one entry");

   a_gen_count: assert property (@(posedge clock) disable iff (reset)
      gen_cnt_ff <= clwt_pkg::GEN_CW'(clwt_pkg::MAX_GENERATORS))
      else $error("generator count overflow");

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clwt_pkg::ST_EOUT && out_free && k_ff == 6'(clwt_pkg::NUM_BINS - 1))
      |=> rsp_tvalid && rsp_tlast && state_ff == clwt_pkg::ST_IDLE)
      else $error("final histogram word not marked last");

endmodule
